// ===== src/mqa_pkg.sv =====
// shared types, constants and the update microprogram of the attitude estimator
`timescale 1ns / 1ps

package mqa_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;

    // register reset values
    localparam logic signed [31:0] GAIN_P_RST = 32'sd22937600;
    localparam logic signed [31:0] GAIN_I_RST = 32'sd196608;
    localparam logic signed [31:0] GAIN_D_RST = 32'sd0;
    localparam logic [23:0]        PERIOD_RST = 24'd83886;

    // attitude after reset (-0.029, 0.068, -0.997, 0 in Q2.30)
    localparam logic signed [31:0] ATT_W_RST = -32'sd31138513;
    localparam logic signed [31:0] ATT_X_RST = 32'sd73014444;
    localparam logic signed [31:0] ATT_Y_RST = -32'sd1070520599;
    localparam logic signed [31:0] ATT_Z_RST = 32'sd0;

    // microprogram step index width and last step index
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] PROG_LAST = 6'd40;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] fixed_rate_x;
        logic signed [31:0] fixed_rate_y;
        logic signed [31:0] fixed_rate_z;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_SHIFT,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT,
        ST_DIV,
        ST_NORM_END,
        ST_PROG_MUL,
        ST_PROG_ACC,
        ST_DONE
    } state_t;

    // operand sources of the shared multiply-accumulate unit
    typedef enum logic [5:0] {
        SRC_ZERO,
        SRC_Q0, SRC_Q1, SRC_Q2, SRC_Q3,
        SRC_QN0, SRC_QN1, SRC_QN2, SRC_QN3,
        SRC_V0, SRC_V1, SRC_V2,
        SRC_AN0, SRC_AN1, SRC_AN2,
        SRC_E0, SRC_E1, SRC_E2,
        SRC_I0, SRC_I1, SRC_I2,
        SRC_G0, SRC_G1, SRC_G2,
        SRC_H0, SRC_H1, SRC_H2,
        SRC_FR0, SRC_FR1, SRC_FR2,
        SRC_ESUM0, SRC_ESUM1, SRC_ESUM2,
        SRC_EDIF0, SRC_EDIF1, SRC_EDIF2,
        SRC_KP, SRC_KI, SRC_KD, SRC_TP
    } src_t;

    typedef enum logic [1:0] {
        SH_30,
        SH_31,
        SH_24,
        SH_11
    } shift_t;

    typedef enum logic [4:0] {
        DST_NONE,
        DST_V0, DST_V1, DST_V2,
        DST_E0, DST_E1, DST_E2,
        DST_I0, DST_I1, DST_I2,
        DST_FR0, DST_FR1, DST_FR2,
        DST_H0, DST_H1, DST_H2,
        DST_QN0, DST_QN1, DST_QN2, DST_QN3
    } dst_t;

    // one step: acc = (load ? init : acc) +/- (a * b >>> sh), then optional write, optionally doubled
    typedef struct packed {
        logic   load;
        src_t   init;
        src_t   a;
        src_t   b;
        shift_t sh;
        logic   neg;
        dst_t   dst;
        logic   dbl;
    } uop_t;

    function automatic uop_t uo(input logic ld, input src_t ini, input src_t a,
                                input src_t b, input shift_t sh, input logic ng,
                                input dst_t d, input logic db);
        uop_t u;
        u.load = ld;
        u.init = ini;
        u.a    = a;
        u.b    = b;
        u.sh   = sh;
        u.neg  = ng;
        u.dst  = d;
        u.dbl  = db;
        return u;
    endfunction

    function automatic uop_t prog_uop(input logic [STEP_W-1:0] idx);
        uop_t u;
        case (idx)
            // gravity direction from the stored attitude
            6'd0:  u = uo(1'b1, SRC_ZERO, SRC_Q1, SRC_Q3, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd1:  u = uo(1'b0, SRC_ZERO, SRC_Q0, SRC_Q2, SH_30, 1'b1, DST_V0,   1'b1);
            6'd2:  u = uo(1'b1, SRC_ZERO, SRC_Q0, SRC_Q1, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd3:  u = uo(1'b0, SRC_ZERO, SRC_Q2, SRC_Q3, SH_30, 1'b0, DST_V1,   1'b1);
            6'd4:  u = uo(1'b1, SRC_ZERO, SRC_Q0, SRC_Q0, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd5:  u = uo(1'b0, SRC_ZERO, SRC_Q1, SRC_Q1, SH_30, 1'b1, DST_NONE, 1'b0);
            6'd6:  u = uo(1'b0, SRC_ZERO, SRC_Q2, SRC_Q2, SH_30, 1'b1, DST_NONE, 1'b0);
            6'd7:  u = uo(1'b0, SRC_ZERO, SRC_Q3, SRC_Q3, SH_30, 1'b0, DST_V2,   1'b0);
            // error as cross product
            6'd8:  u = uo(1'b1, SRC_ZERO, SRC_AN1, SRC_V2, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd9:  u = uo(1'b0, SRC_ZERO, SRC_AN2, SRC_V1, SH_30, 1'b1, DST_E0,   1'b0);
            6'd10: u = uo(1'b1, SRC_ZERO, SRC_AN2, SRC_V0, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd11: u = uo(1'b0, SRC_ZERO, SRC_AN0, SRC_V2, SH_30, 1'b1, DST_E1,   1'b0);
            6'd12: u = uo(1'b1, SRC_ZERO, SRC_AN0, SRC_V1, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd13: u = uo(1'b0, SRC_ZERO, SRC_AN1, SRC_V0, SH_30, 1'b1, DST_E2,   1'b0);
            // x axis: integral, corrected rate, half-step angle
            6'd14: u = uo(1'b1, SRC_I0, SRC_TP, SRC_ESUM0, SH_31, 1'b0, DST_I0, 1'b0);
            6'd15: u = uo(1'b1, SRC_G0, SRC_KP, SRC_E0, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd16: u = uo(1'b0, SRC_ZERO, SRC_KI, SRC_I0, SH_24, 1'b0, DST_NONE, 1'b0);
            6'd17: u = uo(1'b0, SRC_ZERO, SRC_KD, SRC_EDIF0, SH_30, 1'b0, DST_FR0, 1'b0);
            6'd18: u = uo(1'b1, SRC_ZERO, SRC_FR0, SRC_TP, SH_11, 1'b0, DST_H0, 1'b0);
            // y axis
            6'd19: u = uo(1'b1, SRC_I1, SRC_TP, SRC_ESUM1, SH_31, 1'b0, DST_I1, 1'b0);
            6'd20: u = uo(1'b1, SRC_G1, SRC_KP, SRC_E1, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd21: u = uo(1'b0, SRC_ZERO, SRC_KI, SRC_I1, SH_24, 1'b0, DST_NONE, 1'b0);
            6'd22: u = uo(1'b0, SRC_ZERO, SRC_KD, SRC_EDIF1, SH_30, 1'b0, DST_FR1, 1'b0);
            6'd23: u = uo(1'b1, SRC_ZERO, SRC_FR1, SRC_TP, SH_11, 1'b0, DST_H1, 1'b0);
            // z axis
            6'd24: u = uo(1'b1, SRC_I2, SRC_TP, SRC_ESUM2, SH_31, 1'b0, DST_I2, 1'b0);
            6'd25: u = uo(1'b1, SRC_G2, SRC_KP, SRC_E2, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd26: u = uo(1'b0, SRC_ZERO, SRC_KI, SRC_I2, SH_24, 1'b0, DST_NONE, 1'b0);
            6'd27: u = uo(1'b0, SRC_ZERO, SRC_KD, SRC_EDIF2, SH_30, 1'b0, DST_FR2, 1'b0);
            6'd28: u = uo(1'b1, SRC_ZERO, SRC_FR2, SRC_TP, SH_11, 1'b0, DST_H2, 1'b0);
            // quaternion step, later components use updated earlier ones
            6'd29: u = uo(1'b1, SRC_Q0, SRC_Q1, SRC_H0, SH_30, 1'b1, DST_NONE, 1'b0);
            6'd30: u = uo(1'b0, SRC_ZERO, SRC_Q2, SRC_H1, SH_30, 1'b1, DST_NONE, 1'b0);
            6'd31: u = uo(1'b0, SRC_ZERO, SRC_Q3, SRC_H2, SH_30, 1'b1, DST_QN0, 1'b0);
            6'd32: u = uo(1'b1, SRC_Q1, SRC_QN0, SRC_H0, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd33: u = uo(1'b0, SRC_ZERO, SRC_Q2, SRC_H2, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd34: u = uo(1'b0, SRC_ZERO, SRC_Q3, SRC_H1, SH_30, 1'b1, DST_QN1, 1'b0);
            6'd35: u = uo(1'b1, SRC_Q2, SRC_QN0, SRC_H1, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd36: u = uo(1'b0, SRC_ZERO, SRC_QN1, SRC_H2, SH_30, 1'b1, DST_NONE, 1'b0);
            6'd37: u = uo(1'b0, SRC_ZERO, SRC_Q3, SRC_H0, SH_30, 1'b0, DST_QN2, 1'b0);
            6'd38: u = uo(1'b1, SRC_Q3, SRC_QN0, SRC_H2, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd39: u = uo(1'b0, SRC_ZERO, SRC_QN1, SRC_H1, SH_30, 1'b0, DST_NONE, 1'b0);
            6'd40: u = uo(1'b0, SRC_ZERO, SRC_QN2, SRC_H0, SH_30, 1'b1, DST_QN3, 1'b0);
            default: u = uo(1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SH_30, 1'b0, DST_NONE, 1'b0);
        endcase
        return u;
    endfunction

    // saturate a wide accumulator value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [70:0] x);
        logic signed [31:0] r;
        if (x > 71'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -71'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== src/mahony_quaternion_attitude.sv =====
// attitude estimator top level: shared multiply-accumulate, root and divide units
`timescale 1ns / 1ps

// channel   dir  handshake                   payload
// sample    in   sample_valid/sample_ready   sample (sample_t: rates, accel)
// result    out  result_valid/result_ready   result (result_t: quaternion, rates)
// cfg       in   cfg_we                      cfg_index, cfg_data
//
// one transaction runs two vector normalizations, each an abs check, shifts,
// squares of the components, a bit-serial square root, a restoring divide per
// component and an end step, with 41 multiply-accumulate steps in between.
// a zero vector skips its normalization (abs check, then end).
// sample_ready is high only when idle; a finished result waits in the output
// register and a new sample is taken meanwhile, stalling only at its end.
// reset restores the gains, period, attitude, integral and last error.

module mahony_quaternion_attitude
    import mqa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sample_t              sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    state_t state_reg, state_next;

    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [23:0]        tp_reg;

    logic signed [31:0] att_reg [4];
    logic signed [31:0] int_reg [3];
    logic signed [31:0] pe_reg  [3];
    logic signed [31:0] g_reg   [3];
    logic signed [31:0] an_reg  [3];
    logic signed [31:0] v_reg   [3];
    logic signed [31:0] e_reg   [3];
    logic signed [31:0] fr_reg  [3];
    logic signed [31:0] h_reg   [3];
    logic signed [31:0] qn_reg  [4];
    logic signed [31:0] nv_reg  [4];
    logic signed [31:0] nu_reg  [4];
    logic [31:0]        m_reg   [4];

    logic                norm_quat_reg, norm_zero_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [1:0]          comp_reg;
    logic [4:0]          dv_cnt_reg;
    logic signed [67:0]  prod_reg;
    logic signed [70:0]  acc_reg;
    logic [63:0]         sq_s_reg, sq_res_reg, sq_bit_reg;
    logic [31:0]         rem_reg;
    logic [30:0]         quo_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    uop_t               uop;
    logic signed [32:0] esum [3];
    logic signed [32:0] edif [3];
    logic signed [33:0] op_a, op_b, op_init, mul_a, mul_b;
    logic signed [67:0] prod_sh;
    logic signed [70:0] term, base, acc_next, acc_wr;
    logic signed [31:0] wr_val;
    logic [31:0]        abs_m [4];
    logic               abs_top, in_zero, norm_done, out_free;
    logic [64:0]        sq_t;
    logic               sq_ge;
    logic               dv_nb, dv_ge;
    logic [32:0]        dv_t, dv_sub;
    logic [30:0]        dv_quo;
    logic signed [31:0] dv_u;

    assign uop = prog_uop(step_reg);

    // error sum and difference for the integral and derivative terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            esum[i] = 33'(e_reg[i]) + 33'(pe_reg[i]);
            edif[i] = 33'(e_reg[i]) - 33'(pe_reg[i]);
        end
    end

    // operand selection
    function automatic logic signed [33:0] fetch(input src_t s);
        logic signed [33:0] r;
        case (s)
            SRC_Q0:    r = 34'(att_reg[0]);
            SRC_Q1:    r = 34'(att_reg[1]);
            SRC_Q2:    r = 34'(att_reg[2]);
            SRC_Q3:    r = 34'(att_reg[3]);
            SRC_QN0:   r = 34'(qn_reg[0]);
            SRC_QN1:   r = 34'(qn_reg[1]);
            SRC_QN2:   r = 34'(qn_reg[2]);
            SRC_QN3:   r = 34'(qn_reg[3]);
            SRC_V0:    r = 34'(v_reg[0]);
            SRC_V1:    r = 34'(v_reg[1]);
            SRC_V2:    r = 34'(v_reg[2]);
            SRC_AN0:   r = 34'(an_reg[0]);
            SRC_AN1:   r = 34'(an_reg[1]);
            SRC_AN2:   r = 34'(an_reg[2]);
            SRC_E0:    r = 34'(e_reg[0]);
            SRC_E1:    r = 34'(e_reg[1]);
            SRC_E2:    r = 34'(e_reg[2]);
            SRC_I0:    r = 34'(int_reg[0]);
            SRC_I1:    r = 34'(int_reg[1]);
            SRC_I2:    r = 34'(int_reg[2]);
            SRC_G0:    r = 34'(g_reg[0]);
            SRC_G1:    r = 34'(g_reg[1]);
            SRC_G2:    r = 34'(g_reg[2]);
            SRC_H0:    r = 34'(h_reg[0]);
            SRC_H1:    r = 34'(h_reg[1]);
            SRC_H2:    r = 34'(h_reg[2]);
            SRC_FR0:   r = 34'(fr_reg[0]);
            SRC_FR1:   r = 34'(fr_reg[1]);
            SRC_FR2:   r = 34'(fr_reg[2]);
            SRC_ESUM0: r = 34'(esum[0]);
            SRC_ESUM1: r = 34'(esum[1]);
            SRC_ESUM2: r = 34'(esum[2]);
            SRC_EDIF0: r = 34'(edif[0]);
            SRC_EDIF1: r = 34'(edif[1]);
            SRC_EDIF2: r = 34'(edif[2]);
            SRC_KP:    r = 34'(kp_reg);
            SRC_KI:    r = 34'(ki_reg);
            SRC_KD:    r = 34'(kd_reg);
            SRC_TP:    r = $signed({10'd0, tp_reg});
            default:   r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        op_a    = fetch(uop.a);
        op_b    = fetch(uop.b);
        op_init = fetch(uop.init);
    end

    // shared multiplier inputs
    always_comb
    begin
        if (state_reg == ST_SQ_MUL)
        begin
            mul_a = $signed({2'b00, m_reg[0]});
            mul_b = $signed({2'b00, m_reg[0]});
        end
        else
        begin
            mul_a = op_a;
            mul_b = op_b;
        end
    end

    // product scaling and accumulate
    always_comb
    begin
        case (uop.sh)
            SH_30:   prod_sh = prod_reg >>> 30;
            SH_31:   prod_sh = prod_reg >>> 31;
            SH_24:   prod_sh = prod_reg >>> 24;
            SH_11:   prod_sh = prod_reg >>> 11;
            default: prod_sh = prod_reg;
        endcase
        term     = 71'(prod_sh);
        base     = uop.load ? 71'(op_init) : acc_reg;
        acc_next = uop.neg ? base - term : base + term;
        acc_wr   = uop.dbl ? acc_next <<< 1 : acc_next;
        wr_val   = sat32(acc_wr);
    end

    // magnitudes and normalizing checks
    always_comb
    begin
        abs_top   = 1'b0;
        in_zero   = 1'b1;
        norm_done = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            abs_m[i]  = nv_reg[i][31] ? 32'(-nv_reg[i]) : 32'(nv_reg[i]);
            abs_top   = abs_top | abs_m[i][31];
            in_zero   = in_zero & (nv_reg[i] == 32'sd0);
            norm_done = norm_done | m_reg[i][30];
        end
    end

    // one square root step
    always_comb
    begin
        sq_t  = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        sq_ge = {1'b0, sq_s_reg} >= sq_t;
    end

    // one restoring divide step
    always_comb
    begin
        dv_nb  = (dv_cnt_reg == 5'd0) ? m_reg[0][0] : 1'b0;
        dv_t   = {rem_reg, dv_nb};
        dv_ge  = dv_t >= {1'b0, sq_res_reg[31:0]};
        dv_sub = dv_ge ? dv_t - {1'b0, sq_res_reg[31:0]} : dv_t;
        dv_quo = {quo_reg[29:0], dv_ge};
        dv_u   = nv_reg[0][31] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    end

    assign out_free = !result_valid_reg || result_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (sample_valid) state_next = ST_ABS;
            ST_ABS:      state_next = in_zero ? ST_NORM_END : ST_SHIFT;
            ST_SHIFT:    if (norm_done) state_next = ST_SQ_MUL;
            ST_SQ_MUL:   state_next = ST_SQ_ACC;
            ST_SQ_ACC:   state_next = (comp_reg == 2'd3) ? ST_SQRT : ST_SQ_MUL;
            ST_SQRT:     if (sq_bit_reg == 64'd1) state_next = ST_DIV;
            ST_DIV:
            begin
                if (dv_cnt_reg == 5'd30 && comp_reg == 2'd3)
                    state_next = ST_NORM_END;
            end
            ST_NORM_END: state_next = norm_quat_reg ? ST_DONE : ST_PROG_MUL;
            ST_PROG_MUL: state_next = ST_PROG_ACC;
            ST_PROG_ACC: state_next = (step_reg == PROG_LAST) ? ST_ABS : ST_PROG_MUL;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        sample_ready = (state_reg == ST_IDLE);
        result_valid = result_valid_reg;
        result       = result_reg;
    end

    // control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            kp_reg           <= GAIN_P_RST;
            ki_reg           <= GAIN_I_RST;
            kd_reg           <= GAIN_D_RST;
            tp_reg           <= PERIOD_RST;
            att_reg[0]       <= ATT_W_RST;
            att_reg[1]       <= ATT_X_RST;
            att_reg[2]       <= ATT_Y_RST;
            att_reg[3]       <= ATT_Z_RST;
            for (int i = 0; i < 3; i++)
            begin
                int_reg[i] <= '0;
                pe_reg[i]  <= '0;
            end
            norm_quat_reg    <= 1'b0;
            norm_zero_reg    <= 1'b0;
            step_reg         <= '0;
            comp_reg         <= '0;
            dv_cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN_P: kp_reg <= cfg_data;
                    CFG_GAIN_I: ki_reg <= cfg_data;
                    CFG_GAIN_D: kd_reg <= cfg_data;
                    CFG_PERIOD: tp_reg <= cfg_data[23:0];
                    default:    ;
                endcase
            end

            // result register handshake
            if (state_reg == ST_DONE && out_free)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                        norm_quat_reg <= 1'b0;
                end
                ST_ABS:
                begin
                    norm_zero_reg <= in_zero;
                    comp_reg      <= '0;
                end
                ST_SQ_ACC:
                begin
                    comp_reg <= comp_reg + 2'd1;
                end
                ST_SQRT:
                begin
                    dv_cnt_reg <= '0;
                    comp_reg   <= '0;
                end
                ST_DIV:
                begin
                    if (dv_cnt_reg == 5'd30)
                    begin
                        dv_cnt_reg <= '0;
                        comp_reg   <= comp_reg + 2'd1;
                    end
                    else
                        dv_cnt_reg <= dv_cnt_reg + 5'd1;
                end
                ST_NORM_END:
                begin
                    step_reg <= '0;
                    if (norm_quat_reg && !norm_zero_reg)
                    begin
                        for (int i = 0; i < 4; i++)
                            att_reg[i] <= nu_reg[i];
                    end
                end
                ST_PROG_ACC:
                begin
                    case (uop.dst)
                        DST_I0:  int_reg[0] <= wr_val;
                        DST_I1:  int_reg[1] <= wr_val;
                        DST_I2:  int_reg[2] <= wr_val;
                        default: ;
                    endcase
                    if (step_reg == PROG_LAST)
                    begin
                        norm_quat_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                            pe_reg[i] <= e_reg[i];
                    end
                    step_reg <= step_reg + 6'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    g_reg[0]  <= sample.rate_x;
                    g_reg[1]  <= sample.rate_y;
                    g_reg[2]  <= sample.rate_z;
                    nv_reg[0] <= sample.accel_x;
                    nv_reg[1] <= sample.accel_y;
                    nv_reg[2] <= sample.accel_z;
                    nv_reg[3] <= '0;
                end
            end
            ST_ABS:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    m_reg[i]  <= abs_top ? abs_m[i] >> 1 : abs_m[i];
                    nu_reg[i] <= '0;
                end
            end
            ST_SHIFT:
            begin
                if (!norm_done)
                begin
                    for (int i = 0; i < 4; i++)
                        m_reg[i] <= m_reg[i] << 1;
                end
            end
            ST_SQ_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            ST_SQ_ACC:
            begin
                // sum of squares, components rotate through slot zero
                acc_reg <= ((comp_reg == 2'd0) ? 71'sd0 : acc_reg) + 71'(prod_reg);
                for (int i = 0; i < 4; i++)
                    m_reg[i] <= m_reg[(i + 1) % 4];
                if (comp_reg == 2'd3)
                begin
                    sq_s_reg   <= acc_reg[63:0] + prod_reg[63:0];
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                end
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_s_reg   <= sq_s_reg - sq_t[63:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
                rem_reg    <= {1'b0, m_reg[0][31:1]};
            end
            ST_DIV:
            begin
                rem_reg <= dv_sub[31:0];
                quo_reg <= dv_quo;
                if (dv_cnt_reg == 5'd30)
                begin
                    // component finished: store signed quotient, rotate inputs
                    nu_reg[3] <= dv_u;
                    for (int i = 0; i < 3; i++)
                        nu_reg[i] <= nu_reg[i + 1];
                    for (int i = 0; i < 4; i++)
                    begin
                        m_reg[i]  <= m_reg[(i + 1) % 4];
                        nv_reg[i] <= nv_reg[(i + 1) % 4];
                    end
                    rem_reg <= {1'b0, m_reg[1][31:1]};
                end
            end
            ST_NORM_END:
            begin
                if (!norm_quat_reg)
                begin
                    for (int i = 0; i < 3; i++)
                        an_reg[i] <= nu_reg[i];
                end
            end
            ST_PROG_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            ST_PROG_ACC:
            begin
                acc_reg <= acc_next;
                case (uop.dst)
                    DST_V0:  v_reg[0]  <= wr_val;
                    DST_V1:  v_reg[1]  <= wr_val;
                    DST_V2:  v_reg[2]  <= wr_val;
                    DST_E0:  e_reg[0]  <= wr_val;
                    DST_E1:  e_reg[1]  <= wr_val;
                    DST_E2:  e_reg[2]  <= wr_val;
                    DST_FR0: fr_reg[0] <= wr_val;
                    DST_FR1: fr_reg[1] <= wr_val;
                    DST_FR2: fr_reg[2] <= wr_val;
                    DST_H0:  h_reg[0]  <= wr_val;
                    DST_H1:  h_reg[1]  <= wr_val;
                    DST_H2:  h_reg[2]  <= wr_val;
                    DST_QN0: qn_reg[0] <= wr_val;
                    DST_QN1: qn_reg[1] <= wr_val;
                    DST_QN2: qn_reg[2] <= wr_val;
                    DST_QN3: qn_reg[3] <= wr_val;
                    default: ;
                endcase
                // hand the updated quaternion to the normalizer
                if (step_reg == PROG_LAST)
                begin
                    nv_reg[0] <= qn_reg[0];
                    nv_reg[1] <= qn_reg[1];
                    nv_reg[2] <= qn_reg[2];
                    nv_reg[3] <= wr_val;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_reg.quat_w       <= att_reg[0];
                    result_reg.quat_x       <= att_reg[1];
                    result_reg.quat_y       <= att_reg[2];
                    result_reg.quat_z       <= att_reg[3];
                    result_reg.fixed_rate_x <= fr_reg[0];
                    result_reg.fixed_rate_y <= fr_reg[1];
                    result_reg.fixed_rate_z <= fr_reg[2];
                end
            end
            default: ;
        endcase
    end

    // divisor from the square root lies in [2^30, 2^32)
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> sq_res_reg[63:32] == 32'd0 && sq_res_reg[31:30] != 2'd0)
        else $error("square root out of range in divide");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < sq_res_reg[31:0])
        else $error("divide remainder not below divisor");

    // magnitudes are normalized before squaring
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQ_MUL |->
            (m_reg[0][31] | m_reg[1][31] | m_reg[2][31] | m_reg[3][31]) == 1'b0 &&
            (m_reg[0][30] | m_reg[1][30] | m_reg[2][30] | m_reg[3][30]) == 1'b1)
        else $error("vector not normalized before squaring");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the attitude estimator with its own fixed-point predictor
`timescale 1ns / 1ps

module tb_top;
    import mqa_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int RANDOM_PER_PHASE = 190;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    sample_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor copy of registers and state
    longint kp, ki, kd, period;
    longint att[4];
    longint err_int[3];
    longint err_last[3];

    sample_t pending_samples[$];
    result_t attitude_due[$];
    int unsigned sent_cnt = 0;
    int unsigned taken_cnt = 0;
    int unsigned got_cnt = 0;
    int unsigned seen_got = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit idle_mode = 1'b1;
    int errors = 0;
    longint cycles = 0;

    mahony_quaternion_attitude u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip32(input longint x);
        longint r;
        r = x;
        if (x > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (x < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    function automatic longint fmul30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unsigned root64(input longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale to unit length in Q2.30, zero vector gives zero and ok = 0
    task automatic unit_vec(input longint v[4], input int n, output longint u[4],
                            output bit ok);
        longint unsigned m[4];
        longint unsigned big;
        longint unsigned sq;
        longint unsigned r;
        big = 0;
        sq = 0;
        for (int i = 0; i < 4; i++)
        begin
            u[i] = 0;
            m[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > big)
                big = m[i];
        end
        ok = (big != 0);
        if (ok)
        begin
            if (big >= 64'h80000000)
            begin
                for (int i = 0; i < n; i++)
                    m[i] = m[i] >> 1;
                big = big >> 1;
            end
            while (big < 64'h40000000)
            begin
                for (int i = 0; i < n; i++)
                    m[i] = m[i] << 1;
                big = big << 1;
            end
            for (int i = 0; i < n; i++)
                sq = sq + m[i] * m[i];
            r = root64(sq);
            for (int i = 0; i < n; i++)
            begin
                u[i] = longint'((m[i] << 30) / r);
                if (v[i] < 0)
                    u[i] = -u[i];
            end
        end
    endtask

    // one attitude update; advances the predictor state
    task automatic advance_attitude(input sample_t s, output result_t res);
        longint g[3], ac[4], an[4], v[3], e[3], fr[3], h[3], qn[4], qu[4];
        longint inc, d;
        bit ok;
        g[0] = longint'(s.rate_x);
        g[1] = longint'(s.rate_y);
        g[2] = longint'(s.rate_z);
        ac[0] = longint'(s.accel_x);
        ac[1] = longint'(s.accel_y);
        ac[2] = longint'(s.accel_z);
        ac[3] = 0;
        unit_vec(ac, 3, an, ok);

        // gravity predicted by the stored attitude
        v[0] = clip32(2 * (fmul30(att[1], att[3]) - fmul30(att[0], att[2])));
        v[1] = clip32(2 * (fmul30(att[0], att[1]) + fmul30(att[2], att[3])));
        v[2] = clip32(fmul30(att[0], att[0]) - fmul30(att[1], att[1])
                      - fmul30(att[2], att[2]) + fmul30(att[3], att[3]));

        e[0] = clip32(fmul30(an[1], v[2]) - fmul30(an[2], v[1]));
        e[1] = clip32(fmul30(an[2], v[0]) - fmul30(an[0], v[2]));
        e[2] = clip32(fmul30(an[0], v[1]) - fmul30(an[1], v[0]));

        // pid correction per axis
        for (int i = 0; i < 3; i++)
        begin
            inc = (period * (e[i] + err_last[i])) >>> 31;
            d = e[i] - err_last[i];
            err_int[i] = clip32(err_int[i] + inc);
            fr[i] = clip32(g[i] + ((kp * e[i]) >>> 30) + ((ki * err_int[i]) >>> 24)
                           + ((kd * d) >>> 30));
            err_last[i] = e[i];
            h[i] = clip32((fr[i] * period) >>> 11);
        end

        // sequential quaternion step
        qn[0] = clip32(att[0] - fmul30(att[1], h[0]) - fmul30(att[2], h[1])
                       - fmul30(att[3], h[2]));
        qn[1] = clip32(att[1] + fmul30(qn[0], h[0]) + fmul30(att[2], h[2])
                       - fmul30(att[3], h[1]));
        qn[2] = clip32(att[2] + fmul30(qn[0], h[1]) - fmul30(qn[1], h[2])
                       + fmul30(att[3], h[0]));
        qn[3] = clip32(att[3] + fmul30(qn[0], h[2]) + fmul30(qn[1], h[1])
                       - fmul30(qn[2], h[0]));
        unit_vec(qn, 4, qu, ok);
        if (ok)
            for (int i = 0; i < 4; i++)
                att[i] = qu[i];

        res.quat_w = att[0][31:0];
        res.quat_x = att[1][31:0];
        res.quat_y = att[2][31:0];
        res.quat_z = att[3][31:0];
        res.fixed_rate_x = fr[0][31:0];
        res.fixed_rate_y = fr[1][31:0];
        res.fixed_rate_z = fr[2][31:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] act);
        if (expv !== act)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0d (%h) actual %0d (%h)", $time, name,
                     $signed(expv), expv, $signed(act), act);
        end
    endtask

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** mahony_quaternion_attitude: FAILED **");
            $finish;
        end
    end

    // monitor: predict on accepted samples, check accepted results
    always @(posedge clk)
    begin
        result_t due;
        result_t res;
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                advance_attitude(sample, res);
                attitude_due.push_back(res);
                taken_cnt++;
            end
            if (result_valid && result_ready)
            begin
                got_cnt++;
                if (attitude_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: expected none actual %p", $time, result);
                end
                else
                begin
                    due = attitude_due.pop_front();
                    check_field("quat_w", due.quat_w, result.quat_w);
                    check_field("quat_x", due.quat_x, result.quat_x);
                    check_field("quat_y", due.quat_y, result.quat_y);
                    check_field("quat_z", due.quat_z, result.quat_z);
                    check_field("fixed_rate_x", due.fixed_rate_x, result.fixed_rate_x);
                    check_field("fixed_rate_y", due.fixed_rate_y, result.fixed_rate_y);
                    check_field("fixed_rate_z", due.fixed_rate_z, result.fixed_rate_z);
                end
            end
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        logic nxt_valid;
        nxt_valid = sample_valid;
        if (sample_valid && taken_cnt == sent_cnt)
            nxt_valid = 1'b0;
        if (!nxt_valid && rst_n)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_samples.size() > 0)
            begin
                sample <= pending_samples.pop_front();
                nxt_valid = 1'b1;
                sent_cnt++;
                gap_left = idle_mode ? $urandom_range(0, 4) : 0;
            end
        end
        sample_valid <= nxt_valid;
    end

    // result stall
    always @(negedge clk)
    begin
        if (got_cnt != seen_got)
        begin
            seen_got = got_cnt;
            stall_left = idle_mode ? $urandom_range(0, 4) : 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_GAIN_P: kp = longint'($signed(data));
            CFG_GAIN_I: ki = longint'($signed(data));
            CFG_GAIN_D: kd = longint'($signed(data));
            CFG_PERIOD: period = longint'(data[23:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(input logic [31:0] p, input logic [31:0] i,
                             input logic [31:0] d, input logic [31:0] t);
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, i);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_PERIOD, t);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || taken_cnt != sent_cnt || sample_valid
               || attitude_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic sample_t build(input int gx, input int gy, input int gz,
                                     input int ax, input int ay, input int az);
        sample_t s;
        s.rate_x = gx;
        s.rate_y = gy;
        s.rate_z = gz;
        s.accel_x = ax;
        s.accel_y = ay;
        s.accel_z = az;
        return s;
    endfunction

    // mostly plausible motion, some full-range noise, some free fall
    function automatic sample_t random_sample();
        int unsigned sel;
        sample_t s;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            s = build($urandom_range(0, 1 << 20) - (1 << 19),
                      $urandom_range(0, 1 << 20) - (1 << 19),
                      $urandom_range(0, 1 << 20) - (1 << 19),
                      $urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1 << 21) - (1 << 20));
        else if (sel < 9)
            s = build($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            s = build($urandom_range(0, 1 << 18) - (1 << 17),
                      $urandom_range(0, 1 << 18) - (1 << 17),
                      $urandom_range(0, 1 << 18) - (1 << 17), 0, 0, 0);
        return s;
    endfunction

    task automatic run_random(input bit with_idle);
        idle_mode = with_idle;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            pending_samples.push_back(random_sample());
        wait_drained();
    endtask

    // stimulus and end of run
    initial
    begin
        localparam int MAXP = 32'h7fffffff;
        localparam int MINN = 32'h80000000;
        kp = longint'(GAIN_P_RST);
        ki = longint'(GAIN_I_RST);
        kd = longint'(GAIN_D_RST);
        period = longint'(PERIOD_RST);
        att[0] = longint'(ATT_W_RST);
        att[1] = longint'(ATT_X_RST);
        att[2] = longint'(ATT_Y_RST);
        att[3] = longint'(ATT_Z_RST);
        for (int i = 0; i < 3; i++)
        begin
            err_int[i] = 0;
            err_last[i] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed samples at reset settings
        idle_mode = 1'b1;
        pending_samples.push_back(build(0, 0, 0, 0, 0, 65536));
        pending_samples.push_back(build(0, 0, 0, 0, 0, 0));
        pending_samples.push_back(build(1000, -2000, 3000, 0, 0, 0));
        pending_samples.push_back(build(0, 0, 0, MINN, MINN, MINN));
        pending_samples.push_back(build(0, 0, 0, MAXP, MAXP, MAXP));
        pending_samples.push_back(build(0, 0, 0, MINN, 0, 1));
        pending_samples.push_back(build(0, 0, 0, 1, 0, 0));
        pending_samples.push_back(build(0, 0, 0, -1, -1, -1));
        pending_samples.push_back(build(65536, 0, 0, 0, 65536, 0));
        pending_samples.push_back(build(MAXP, MAXP, MAXP, 100, 200, 300));
        pending_samples.push_back(build(MINN, MINN, MINN, -100, 200, -300));
        pending_samples.push_back(build(MAXP, MINN, 0, 0, 0, 0));
        pending_samples.push_back(build(MINN, 0, MAXP, 0, MINN, 0));
        pending_samples.push_back(build(-1, -1, -1, MAXP, MINN, MAXP));
        pending_samples.push_back(build(0, 0, 0, 65536 * 9, -65536, 65536));
        pending_samples.push_back(build(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f,
                                        32'hf0f0f0f0, 32'h33333333, 32'hcccccccc));
        wait_drained();
        run_random(1'b1);

        // extremes of every register, no idling
        set_gains(MAXP, MINN, MAXP, 32'h00ffffff);
        run_random(1'b0);

        set_gains(0, 0, MINN, 0);
        run_random(1'b1);

        // writes to indexes past the register file must be ignored
        set_gains(MINN, MAXP, 32'h00008000, 1);
        write_reg(CFG_NONE_A, 32'h12345678);
        write_reg(CFG_NONE_B, MAXP);
        run_random(1'b1);

        // plausible tuning
        set_gains(32'h00020000, 32'h00000ccc, 32'h00008000, 32'd167772);
        run_random(1'b0);

        set_gains($urandom, $urandom, $urandom, $urandom_range(0, 32'h00ffffff));
        run_random(1'b1);

        wait_drained();
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("** mahony_quaternion_attitude: PASSED **");
        else
            $display("** mahony_quaternion_attitude: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mqa_pkg.sv
src/mahony_quaternion_attitude.sv
verif/tb_top.sv
